/* rtl/core/fpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  // Default number of fraction bits (Q24.8)
  localparam int unsigned FracBitsDef = 8;

  // Operation select
  typedef enum logic [3:0] {
    CMD_FROM_INT   = 4'd0,
    CMD_FROM_FLOAT = 4'd1,
    CMD_TO_INT     = 4'd2,
    CMD_TO_FLOAT   = 4'd3,
    CMD_ADD        = 4'd4,
    CMD_SUB        = 4'd5,
    CMD_MUL        = 4'd6,
    CMD_DIV        = 4'd7,
    CMD_COMPARE    = 4'd8,
    CMD_MIN        = 4'd9,
    CMD_MAX        = 4'd10,
    CMD_INC        = 4'd11,
    CMD_DEC        = 4'd12
  } cmd_e;

  // One result item
  typedef struct packed {
    logic [31:0] raw_result;
    logic [31:0] int_result;
    logic [31:0] float_result;
    logic        is_greater;
    logic        is_less;
    logic        is_equal;
    logic        div_by_zero;
    logic        conv_overflow;
  } res_t;

  // Side band that rides along the divider stages
  typedef struct packed {
    logic neg;
    logic is_div;
    res_t res;
  } div_side_t;

endpackage

`default_nettype wire

/* rtl/core/fpa_div_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, DW stages deep.
module fpa_div_pipe import fpa_pkg::*; #(
  parameter int unsigned DW = 32 + FracBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [31:0]   divisor_i,
  input  wire div_side_t     side_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [DW-1:0]      quot_o,
  output div_side_t          side_o
);

  logic            v_q    [DW];
  logic            rdy    [DW];
  logic [31:0]     rem_q  [DW];
  logic [DW-1:0]   dq_q   [DW];
  logic [31:0]     dvs_q  [DW];
  div_side_t       side_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          v_p;
    logic [31:0]   rem_p;
    logic [DW-1:0] dq_p;
    logic [31:0]   dvs_p;
    div_side_t     side_p;
    logic          nxt_rdy;
    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid_i;
      assign rem_p  = '0;
      assign dq_p   = dividend_i;
      assign dvs_p  = divisor_i;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign dq_p   = dq_q[k-1];
      assign dvs_p  = dvs_q[k-1];
      assign side_p = side_q[k-1];
    end

    if (k == DW - 1) begin : g_last
      assign nxt_rdy = out_ready_i;
    end else begin : g_mid
      assign nxt_rdy = rdy[k+1];
    end

    assign rdy[k] = !v_q[k] || nxt_rdy;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
      trial = {rem_p, dq_p[DW-1]};
      diff  = trial - {1'b0, dvs_p};
      ge    = trial >= {1'b0, dvs_p};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= ge ? diff[31:0] : trial[31:0];
        dq_q[k]   <= {dq_p[DW-2:0], ge};
        dvs_q[k]  <= dvs_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DW-1];
  assign quot_o      = dq_q[DW-1];
  assign side_o      = side_q[DW-1];

endmodule

`default_nettype wire

/* rtl/core/fixed_point_alu_q24_8.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | dir | tdata (low bit up)                                     | tuser
// s_axis  | in  | raw_a, raw_b, int_value, float_bits (128 b)            | cmd (4 b)
// m_axis  | out | raw_result, int_result, float_result, is_greater,      | -
//         |     | is_less, is_equal, div_by_zero, conv_overflow, 3 pad   |
//
// One item per cycle in and out unless m_axis_tready stalls the chain; the
// depth is set by the one-bit-per-stage divider.
// Stages: input reg, decode, shift/normalize, round, 32+FRAC_BITS divider
// stages, output reg. Each stage holds on stall and fills bubbles.
// Reset (rst_ni low) clears only the valid bits.
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // raw_a, raw_b, int_value, float_bits
  input  wire logic [127:0] s_axis_tdata,
  // cmd
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // raw_result, int_result, float_result, is_greater, is_less, is_equal,
  // div_by_zero, conv_overflow, zero pad
  output logic [103:0]      m_axis_tdata
);

  localparam int unsigned DW = 32 + FRAC_BITS;

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic div_in_ready, div_out_valid;

  // ---------------- stage A: input register
  cmd_e        cmd_a_q;
  logic [31:0] ra_a_q, rb_a_q, iv_a_q, fb_a_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      cmd_a_q <= cmd_e'(s_axis_tuser);
      ra_a_q  <= s_axis_tdata[31:0];
      rb_a_q  <= s_axis_tdata[63:32];
      iv_a_q  <= s_axis_tdata[95:64];
      fb_a_q  <= s_axis_tdata[127:96];
    end
  end

  // ---------------- stage B: decode, simple ops, multiply
  cmd_e               cmd_b_q;
  res_t               res_b_d, res_b_q;
  logic signed [63:0] prod_b_d, prod_b_q;
  logic               ff_neg_d, ff_spec_d, ff_nan_d, ff_mz_d;
  logic [23:0]        ff_m_d;
  logic signed [9:0]  ff_sh_d;
  logic               ff_neg_b_q, ff_spec_b_q, ff_nan_b_q, ff_mz_b_q;
  logic [23:0]        ff_m_b_q;
  logic signed [9:0]  ff_sh_b_q;
  logic               tf_sign_d, tf_sign_b_q;
  logic [31:0]        tf_mag_d, tf_mag_b_q;
  logic               dv_neg_d, dv_neg_b_q;
  logic [DW-1:0]      dv_dnd_d, dv_dnd_b_q;
  logic [31:0]        dv_dvs_d, dv_dvs_b_q;
  logic [31:0]        abs_a, abs_b;
  logic signed [31:0] sa, sb;

  always_comb begin
    sa       = $signed(ra_a_q);
    sb       = $signed(rb_a_q);
    abs_a    = ra_a_q[31] ? (32'd0 - ra_a_q) : ra_a_q;
    abs_b    = rb_a_q[31] ? (32'd0 - rb_a_q) : rb_a_q;
    res_b_d  = '0;
    prod_b_d = 64'(sa) * 64'(sb);
    case (cmd_a_q)
      CMD_FROM_INT: res_b_d.raw_result = iv_a_q << FRAC_BITS;
      CMD_TO_INT:   res_b_d.int_result = 32'(sa >>> FRAC_BITS);
      CMD_ADD:      res_b_d.raw_result = ra_a_q + rb_a_q;
      CMD_SUB:      res_b_d.raw_result = ra_a_q - rb_a_q;
      CMD_DIV:      res_b_d.div_by_zero = (rb_a_q == 32'd0);
      CMD_COMPARE: begin
        res_b_d.is_greater = sa > sb;
        res_b_d.is_less    = sa < sb;
        res_b_d.is_equal   = sa == sb;
      end
      CMD_MIN:      res_b_d.raw_result = (sa < sb) ? ra_a_q : rb_a_q;
      CMD_MAX:      res_b_d.raw_result = (sa > sb) ? ra_a_q : rb_a_q;
      CMD_INC:      res_b_d.raw_result = ra_a_q + 32'd1;
      CMD_DEC:      res_b_d.raw_result = ra_a_q - 32'd1;
      default:      res_b_d = '0;
    endcase

    // float to fixed: unpack and find the scale
    ff_neg_d  = fb_a_q[31];
    ff_spec_d = fb_a_q[30:23] == 8'hFF;
    ff_nan_d  = fb_a_q[22:0] != 23'd0;
    ff_m_d    = {fb_a_q[30:23] != 8'd0, fb_a_q[22:0]};
    ff_mz_d   = ff_m_d == 24'd0;
    if (fb_a_q[30:23] == 8'd0) begin
      ff_sh_d = $signed(10'(FRAC_BITS)) - 10'sd149;
    end else begin
      ff_sh_d = $signed({2'b00, fb_a_q[30:23]}) - 10'sd150 + $signed(10'(FRAC_BITS));
    end

    // fixed to float: sign and magnitude
    tf_sign_d = ra_a_q[31];
    tf_mag_d  = abs_a;

    // divide: magnitudes, widened dividend
    dv_neg_d = ra_a_q[31] ^ rb_a_q[31];
    dv_dnd_d = DW'(abs_a) << FRAC_BITS;
    dv_dvs_d = abs_b;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      cmd_b_q     <= cmd_a_q;
      res_b_q     <= res_b_d;
      prod_b_q    <= prod_b_d;
      ff_neg_b_q  <= ff_neg_d;
      ff_spec_b_q <= ff_spec_d;
      ff_nan_b_q  <= ff_nan_d;
      ff_mz_b_q   <= ff_mz_d;
      ff_m_b_q    <= ff_m_d;
      ff_sh_b_q   <= ff_sh_d;
      tf_sign_b_q <= tf_sign_d;
      tf_mag_b_q  <= tf_mag_d;
      dv_neg_b_q  <= dv_neg_d;
      dv_dnd_b_q  <= dv_dnd_d;
      dv_dvs_b_q  <= dv_dvs_d;
    end
  end

  // ---------------- stage C: product shift, mantissa shift, leading one
  cmd_e               cmd_c_q;
  res_t               res_c_d, res_c_q;
  logic signed [63:0] prod_sh;
  logic [63:0]        ff_sl;
  logic [9:0]         ff_n;
  logic [4:0]         ff_ni;
  logic [32:0]        ff_mag_d, ff_mag_c_q;
  logic [4:0]         tf_p_d, tf_p_c_q;
  logic               ff_neg_c_q, ff_spec_c_q, ff_nan_c_q, ff_mz_c_q;
  logic               tf_sign_c_q;
  logic [31:0]        tf_mag_c_q;
  logic               dv_neg_c_q;
  logic [DW-1:0]      dv_dnd_c_q;
  logic [31:0]        dv_dvs_c_q;

  always_comb begin
    res_c_d = res_b_q;
    prod_sh = prod_b_q >>> FRAC_BITS;
    if (cmd_b_q == CMD_MUL) begin
      res_c_d.raw_result = prod_sh[31:0];
    end

    // scaled magnitude, forced above 2^31 when it cannot fit
    ff_sl    = 64'(ff_m_b_q) << ff_sh_b_q[5:0];
    ff_n     = 10'(-ff_sh_b_q);
    ff_ni    = ff_n[4:0] - 5'd1;
    ff_mag_d = '0;
    if (ff_sh_b_q >= 0) begin
      if (ff_sh_b_q > 10'sd39 || ff_sl[63:33] != '0) begin
        ff_mag_d = 33'h1_0000_0000;
      end else begin
        ff_mag_d = ff_sl[32:0];
      end
    end else if (ff_n < 10'd25) begin
      ff_mag_d = 33'(ff_m_b_q >> ff_n[4:0]) + 33'(ff_m_b_q[ff_ni]);
    end

    // leading one position
    tf_p_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (tf_mag_b_q[i]) tf_p_d = 5'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      cmd_c_q     <= cmd_b_q;
      res_c_q     <= res_c_d;
      ff_mag_c_q  <= ff_mag_d;
      tf_p_c_q    <= tf_p_d;
      ff_neg_c_q  <= ff_neg_b_q;
      ff_spec_c_q <= ff_spec_b_q;
      ff_nan_c_q  <= ff_nan_b_q;
      ff_mz_c_q   <= ff_mz_b_q;
      tf_sign_c_q <= tf_sign_b_q;
      tf_mag_c_q  <= tf_mag_b_q;
      dv_neg_c_q  <= dv_neg_b_q;
      dv_dnd_c_q  <= dv_dnd_b_q;
      dv_dvs_c_q  <= dv_dvs_b_q;
    end
  end

  // ---------------- stage D: saturate and round the conversions
  res_t        res_d_d;
  div_side_t   side_d_q;
  logic [DW-1:0] dv_dnd_d_q;
  logic [31:0]   dv_dvs_d_q;
  logic [4:0]  tf_s;
  logic [31:0] tf_rem, tf_half;
  logic [24:0] tf_keep;
  logic [5:0]  tf_p;
  logic [7:0]  tf_be;

  always_comb begin
    res_d_d = res_c_q;

    if (cmd_c_q == CMD_FROM_FLOAT) begin
      if (ff_spec_c_q) begin
        res_d_d.conv_overflow = 1'b1;
        res_d_d.raw_result    = ff_nan_c_q ? 32'd0 :
                                (ff_neg_c_q ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else if (ff_mz_c_q) begin
        res_d_d.raw_result = 32'd0;
      end else if (!ff_neg_c_q) begin
        if (ff_mag_c_q > 33'h0_7FFF_FFFF) begin
          res_d_d.conv_overflow = 1'b1;
          res_d_d.raw_result    = 32'h7FFF_FFFF;
        end else begin
          res_d_d.raw_result = ff_mag_c_q[31:0];
        end
      end else begin
        if (ff_mag_c_q > 33'h0_8000_0000) begin
          res_d_d.conv_overflow = 1'b1;
          res_d_d.raw_result    = 32'h8000_0000;
        end else begin
          res_d_d.raw_result = 32'd0 - ff_mag_c_q[31:0];
        end
      end
    end

    // fixed to float, round to nearest even
    tf_s    = tf_p_c_q - 5'd23;
    tf_rem  = tf_mag_c_q & ((32'd1 << tf_s) - 32'd1);
    tf_half = 32'd1 << (tf_s - 5'd1);
    tf_p    = {1'b0, tf_p_c_q};
    if (tf_p_c_q > 5'd23) begin
      tf_keep = 25'(tf_mag_c_q >> tf_s);
      if (tf_rem > tf_half || (tf_rem == tf_half && tf_keep[0])) begin
        tf_keep = tf_keep + 25'd1;
      end
      if (tf_keep[24]) begin
        tf_keep = tf_keep >> 1;
        tf_p    = tf_p + 6'd1;
      end
    end else begin
      tf_keep = 25'(tf_mag_c_q << (5'd23 - tf_p_c_q));
    end
    tf_be = 8'(tf_p) + 8'd127 - 8'(FRAC_BITS);
    if (cmd_c_q == CMD_TO_FLOAT && tf_mag_c_q != 32'd0) begin
      res_d_d.float_result = {tf_sign_c_q, tf_be, tf_keep[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      side_d_q.res    <= res_d_d;
      side_d_q.neg    <= dv_neg_c_q;
      side_d_q.is_div <= cmd_c_q == CMD_DIV;
      dv_dnd_d_q      <= dv_dnd_c_q;
      dv_dvs_d_q      <= dv_dvs_c_q;
    end
  end

  // ---------------- divider stages
  logic [DW-1:0] quot;
  div_side_t     side_o;

  fpa_div_pipe #(
    .DW (DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vd_q),
    .in_ready_o  (div_in_ready),
    .dividend_i  (dv_dnd_d_q),
    .divisor_i   (dv_dvs_d_q),
    .side_i      (side_d_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy_e),
    .quot_o      (quot),
    .side_o      (side_o)
  );

  // ---------------- stage E: output register
  res_t res_e_d, res_e_q;

  always_comb begin
    res_e_d = side_o.res;
    if (side_o.is_div && !side_o.res.div_by_zero) begin
      res_e_d.raw_result = side_o.neg ? (32'd0 - quot[31:0]) : quot[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      res_e_q <= res_e_d;
    end
  end

  // ---------------- handshake chain
  assign rdy_e = !ve_q || m_axis_tready;
  assign rdy_d = !vd_q || div_in_ready;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_axis_tvalid;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= div_out_valid;
    end
  end

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = ve_q;
  assign m_axis_tdata  = {3'b000,
                          res_e_q.conv_overflow,
                          res_e_q.div_by_zero,
                          res_e_q.is_equal,
                          res_e_q.is_less,
                          res_e_q.is_greater,
                          res_e_q.float_result,
                          res_e_q.int_result,
                          res_e_q.raw_result};

endmodule

`default_nettype wire

/* rtl/core/fpa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpa_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata
);

  // A stalled item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // A stalled item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  // At most one compare flag per item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones(m_axis_tdata[98:96]) <= 1)
    else $error("more than one compare flag set");

  // Divide and float-convert flags never come from the same command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[99] && m_axis_tdata[100]))
    else $error("div_by_zero and conv_overflow both set");

  // Pad bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[103:101] == 3'b000)
    else $error("output pad bits not zero");

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import fpa_pkg::*;

  localparam int FB = FracBitsDef;
  // Commands outside the enum; they must give an all-zero result
  localparam logic [3:0] CMD_SPARE_LO = 4'd13;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // raw_a, raw_b, int_value, float_bits
  logic [127:0] s_axis_tdata = '0;
  // cmd
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // raw_result, int_result, float_result, is_greater, is_less, is_equal,
  // div_by_zero, conv_overflow, zero pad
  logic [103:0] m_axis_tdata;

  res_t pending_results[$];
  int   err_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_seq = 0;
  int   hold_ack = 0;
  int   hold_cnt = 0;

  fixed_point_alu_q24_8 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_point_alu_q24_8 verification failed");
      $finish;
    end
  end

  // Single precision pattern to fixed point, round half away from zero
  function automatic logic [31:0] float_to_q(input logic [31:0] f, output logic ovf);
    logic            neg;
    int              ex;
    int              sh;
    int              n;
    longint unsigned man;
    longint unsigned mag;
    longint unsigned rem;
    neg = f[31];
    ex  = int'(f[30:23]);
    man = longint'(f[22:0]);
    ovf = 1'b0;
    if (ex == 255) begin
      ovf = 1'b1;
      if (man != 0) return 32'h0;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (ex == 0) sh = -149 + FB;
    else begin
      man = man | 64'h80_0000;
      sh = ex - 150 + FB;
    end
    if (man == 0) return 32'h0;
    if (sh >= 0) begin
      mag = (sh > 39) ? (64'd1 << 40) : (man << sh);
    end else begin
      n = -sh;
      if (n >= 25) mag = 0;
      else begin
        rem = man & ((64'd1 << n) - 1);
        mag = man >> n;
        if (rem >= (64'd1 << (n - 1))) mag = mag + 1;
      end
    end
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return 32'h0 - mag[31:0];
  endfunction

  // Fixed point to single precision, round to nearest even
  function automatic logic [31:0] q_to_float(input longint v);
    logic            sgn;
    longint unsigned mag;
    longint unsigned keep;
    longint unsigned rem;
    longint unsigned half;
    int              p;
    int              s;
    logic [31:0]     bexp;
    if (v == 0) return 32'h0;
    sgn = v < 0;
    mag = sgn ? -v : v;
    p = 0;
    while ((mag >> (p + 1)) != 0) p++;
    if (p > 23) begin
      s = p - 23;
      rem = mag & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      keep = mag >> s;
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        p++;
      end
    end else begin
      keep = mag << (23 - p);
    end
    bexp = p - FB + 127;
    return {sgn, bexp[7:0], keep[22:0]};
  endfunction

  // Expected result of one command
  function automatic res_t alu_expect(input logic [3:0] cmd, input logic [31:0] a,
                                      input logic [31:0] b, input logic [31:0] iv,
                                      input logic [31:0] fb);
    res_t   r;
    longint sa;
    longint sb;
    longint prod;
    longint quo;
    logic   ovf;
    r = '0;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    case (cmd)
      CMD_FROM_INT: r.raw_result = iv << FB;
      CMD_FROM_FLOAT: begin
        r.raw_result = float_to_q(fb, ovf);
        r.conv_overflow = ovf;
      end
      CMD_TO_INT: r.int_result = 32'(sa >>> FB);
      CMD_TO_FLOAT: r.float_result = q_to_float(sa);
      CMD_ADD: r.raw_result = a + b;
      CMD_SUB: r.raw_result = a - b;
      CMD_MUL: begin
        prod = sa * sb;
        r.raw_result = 32'(prod >>> FB);
      end
      CMD_DIV: begin
        if (sb == 0) r.div_by_zero = 1'b1;
        else begin
          quo = (sa * (64'sd1 <<< FB)) / sb;
          r.raw_result = 32'(quo);
        end
      end
      CMD_COMPARE: begin
        r.is_greater = sa > sb;
        r.is_less = sa < sb;
        r.is_equal = sa == sb;
      end
      CMD_MIN: r.raw_result = (sa < sb) ? a : b;
      CMD_MAX: r.raw_result = (sa > sb) ? a : b;
      CMD_INC: r.raw_result = a + 32'd1;
      CMD_DEC: r.raw_result = a - 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Compare one received item with the oldest expectation
  task automatic check_item(input logic [103:0] data);
    res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected item", data[31:0], 32'h0);
      return;
    end
    want = pending_results.pop_front();
    if (data[31:0] !== want.raw_result)
      report_mismatch("raw_result", data[31:0], want.raw_result);
    if (data[63:32] !== want.int_result)
      report_mismatch("int_result", data[63:32], want.int_result);
    if (data[95:64] !== want.float_result)
      report_mismatch("float_result", data[95:64], want.float_result);
    if (data[96] !== want.is_greater) report_mismatch("is_greater", data[96], want.is_greater);
    if (data[97] !== want.is_less) report_mismatch("is_less", data[97], want.is_less);
    if (data[98] !== want.is_equal) report_mismatch("is_equal", data[98], want.is_equal);
    if (data[99] !== want.div_by_zero)
      report_mismatch("div_by_zero", data[99], want.div_by_zero);
    if (data[100] !== want.conv_overflow)
      report_mismatch("conv_overflow", data[100], want.conv_overflow);
    if (data[103:101] !== 3'b0) report_mismatch("pad", data[103:101], 32'h0);
  endtask

  // Result side: check accepted items, drive tready, long hold on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_item(m_axis_tdata);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seq != hold_ack) begin
      hold_ack <= hold_seq;
      hold_cnt <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (recv_idle_pct == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item and wait until it is taken
  task automatic send_item(input logic [3:0] cmd, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] iv,
                           input logic [31:0] fb);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {fb, iv, b, a};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(alu_expect(cmd, a, b, iv, fb));
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000 ^ ($urandom_range(3));
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'($signed($urandom_range(8192)) - 4096);
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [7:0] ex;
    ex = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(170, 100));
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  function automatic logic [3:0] pick_cmd();
    if ($urandom_range(19) == 0) return 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    return 4'($urandom_range(CMD_DEC, CMD_FROM_INT));
  endfunction

  task automatic test_directed();
    send_item(CMD_FROM_INT, 0, 0, 32'h7FFF_FFFF, 0);
    send_item(CMD_FROM_INT, 0, 0, 32'h8000_0000, 0);
    send_item(CMD_FROM_INT, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'h7FC0_0000);   // NaN
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'h7F80_0000);   // +inf
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'hFF80_0000);   // -inf
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'h8000_0000);   // negative zero
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'h0000_0001);   // denormal
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'h3BC0_0000);   // tie at 1.5 lsb
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'hBBC0_0000);   // negative tie
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'h4B00_0000);   // exactly 2^23, saturates
    send_item(CMD_FROM_FLOAT, 0, 0, 0, 32'hCB00_0000);   // -2^23, fits
    send_item(CMD_TO_INT, 32'h8000_0000, 0, 0, 0);
    send_item(CMD_TO_INT, 32'hFFFF_FFFF, 0, 0, 0);
    send_item(CMD_TO_FLOAT, 0, 0, 0, 0);
    send_item(CMD_TO_FLOAT, 32'h8000_0000, 0, 0, 0);
    send_item(CMD_TO_FLOAT, 32'h0100_0001, 0, 0, 0);     // tie, rounds to even
    send_item(CMD_TO_FLOAT, 32'h0100_0003, 0, 0, 0);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h1, 0, 0);
    send_item(CMD_SUB, 32'h8000_0000, 32'h1, 0, 0);
    send_item(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_item(CMD_DIV, 32'h100, 0, 0, 0);                // zero divisor
    send_item(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_COMPARE, 32'h1234, 32'h1234, 0, 0);
    send_item(CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_item(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_item(CMD_INC, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(CMD_DEC, 32'h8000_0000, 0, 0, 0);
    send_item(CMD_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_SPARE_HI, 32'h1, 32'h1, 32'h1, 32'h1);
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_item(pick_cmd(), pick_word(), pick_word(), $urandom, pick_float());
  endtask

  // Long receiver stall while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq = hold_seq + 1;
    repeat (200) send_item(pick_cmd(), pick_word(), pick_word(), $urandom, pick_float());
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 46;
    test_directed();
    test_random(500, 38, 46);
    test_random(500, 46, 38);
    test_backpressure();
    test_random(400, 0, 0);
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("items never received", pending_results.size(), 32'h0);
    if (err_count == 0) begin
      $display("fixed_point_alu_q24_8 verification clean");
    end else begin
      $display("fixed_point_alu_q24_8 verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fpa_pkg.sv
rtl/core/fpa_div_pipe.sv
rtl/core/fixed_point_alu_q24_8.sv
rtl/core/fpa_checker.sv
tb/tb_top.sv
